// File: rtl/rpn_pkg.sv
// Shared types and constants for the RPN expression evaluator
package rpn_pkg;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_MUL   = 8'h2A;
   localparam logic [7:0] CHAR_DIV   = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam int unsigned VALUE_OUT_WIDTH = 32;
   localparam int unsigned MIN_TOKENS      = 3;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_BAD   = 3'd1,
      ST_FEW   = 3'd2,
      ST_UNDER = 3'd3,
      ST_DIVZ  = 3'd4,
      ST_OVER  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      OP_PUSH = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_NONE = 3'd5
   } op_type;

   // One classified token (or end marker) handed from front to back
   typedef struct packed {
      op_type     op;
      logic [3:0] digit;
      logic       last;
      status_type early;
   } token_type;

endpackage

// File: rtl/rpn_front.sv
// Front end: gathers characters into tokens and classifies them
module rpn_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_expr_byte,
   input  logic              req_last_byte,
   output logic              tok_valid,
   input  logic              tok_ready,
   output rpn_pkg::token_type tok_data
);
   import rpn_pkg::*;

   logic [7:0] char_ff, char_in;
   logic [1:0] len_ff, len_in;
   logic [1:0] total_ff, total_in;
   logic       bad_ff, bad_in;

   logic [7:0] fc;
   logic [1:0] fl, t1;
   logic       fin, is_dig, is_op, b1, emit;
   op_type     fop;

   assign req_ready = tok_ready;

   always_comb begin
      char_in  = char_ff;
      len_in   = len_ff;
      fc       = char_ff;
      fl       = len_ff;
      if (req_expr_byte != CHAR_SPACE) begin
         if (len_ff == 2'd0) fc = req_expr_byte;
         fl = (len_ff < 2'd2) ? len_ff + 2'd1 : len_ff;
      end
      fin    = (req_expr_byte == CHAR_SPACE) || req_last_byte;
      is_dig = fc inside {[CHAR_ZERO:CHAR_NINE]};
      is_op  = fc inside {CHAR_PLUS, CHAR_MINUS, CHAR_MUL, CHAR_DIV};
      case (fc)
         CHAR_PLUS:  fop = OP_ADD;
         CHAR_MINUS: fop = OP_SUB;
         CHAR_MUL:   fop = OP_MUL;
         CHAR_DIV:   fop = OP_DIV;
         default:    fop = OP_PUSH;
      endcase
      t1 = total_ff;
      b1 = bad_ff;
      tok_data.op    = OP_NONE;
      tok_data.digit = 4'(fc - CHAR_ZERO);
      tok_data.last  = req_last_byte;
      emit = req_last_byte;
      if (fin && fl != 2'd0) begin
         if (total_ff != 2'd3) t1 = total_ff + 2'd1;
         if (fl == 2'd2 || !(is_dig || is_op)) b1 = 1'b1;
         else begin
            tok_data.op = fop;
            emit = 1'b1;
         end
      end
      if (b1) tok_data.early = ST_BAD;
      else if (t1 != 2'd3) tok_data.early = ST_FEW;
      else tok_data.early = ST_OK;
      if (fin) begin
         char_in = 8'd0;
         len_in  = 2'd0;
      end else begin
         char_in = fc;
         len_in  = fl;
      end
      tok_valid = req_valid && emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff  <= 8'd0;
         len_ff   <= 2'd0;
         total_ff <= 2'd0;
         bad_ff   <= 1'b0;
      end else if (req_valid && req_ready) begin
         char_ff  <= char_in;
         len_ff   <= len_in;
         total_ff <= req_last_byte ? 2'd0 : t1;
         bad_ff   <= req_last_byte ? 1'b0 : b1;
      end
   end

endmodule

// File: rtl/rpn_fifo.sv
// Short queue of tokens between front and back
module rpn_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rpn_pkg::token_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rpn_pkg::token_type out_data
);
   import rpn_pkg::*;

   token_type  mem_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = cnt_ff != 3'd4;
   assign out_valid = cnt_ff != 3'd0;
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_data;
      if (reset) begin
         wr_ff  <= 2'd0;
         rd_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         if (push) wr_ff <= wr_ff + 2'd1;
         if (pop)  rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 3'd4)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 3'd0) |-> !pop) else $error("pop from empty queue");

endmodule

// File: rtl/rpn_back.sv
// Back end: stack, arithmetic unit and iterative divider
module rpn_back #(
   parameter int STACK_DEPTH = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        tok_valid,
   output logic                        tok_ready,
   input  rpn_pkg::token_type          tok_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [31:0]          rsp_value,
   output logic [2:0]                  rsp_status
);
   import rpn_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int QW = $clog2(VALUE_WIDTH + 1);
   localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_FIN, S_OUT
   } state_type;

   logic [VALUE_WIDTH-1:0] stack_mem [STACK_DEPTH];
   logic [VALUE_WIDTH-1:0] rdata_ff;

   state_type              state_ff;
   logic [CW-1:0]          count_ff;
   status_type             err_ff;
   token_type              tok_ff;
   logic [VALUE_WIDTH-1:0] top_ff, sec_ff, res_ff, bottom_ff;
   logic [VALUE_WIDTH-1:0] quo_ff, den_ff;
   logic [VALUE_WIDTH:0]   rem_ff;
   logic [QW-1:0]          step_ff;
   logic                   neg_ff;
   logic                   rsp_valid_ff;
   logic [31:0]            rsp_value_ff;
   status_type             rsp_status_ff;

   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          wr_addr;
   logic                   wr_en;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH-1:0] mag_a, mag_b;

   assign tok_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   assign mag_a = sec_ff[VALUE_WIDTH-1] ? -sec_ff : sec_ff;
   assign mag_b = top_ff[VALUE_WIDTH-1] ? -top_ff : top_ff;
   assign trial = {rem_ff[VALUE_WIDTH-1:0], quo_ff[VALUE_WIDTH-1]} - {1'b0, den_ff};

   always_comb begin
      rd_addr = AW'(count_ff - CW'(1));
      if (state_ff == S_RD1) rd_addr = AW'(count_ff - CW'(2));
      wr_addr = AW'(count_ff);
      wr_en   = 1'b0;
      wr_data = res_ff;
      if (state_ff == S_IDLE && tok_valid && tok_ready && tok_data.op == OP_PUSH
          && err_ff == ST_OK && count_ff != FULL) begin
         wr_en   = 1'b1;
         wr_data = VALUE_WIDTH'(tok_data.digit);
      end
      if (state_ff == S_FIN) begin
         wr_en   = 1'b1;
         wr_addr = AW'(count_ff - CW'(2));
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) stack_mem[wr_addr] <= wr_data;
      rdata_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (tok_valid && tok_ready) begin
               tok_ff <= tok_data;
               if (tok_data.op == OP_PUSH && err_ff == ST_OK) begin
                  if (count_ff == FULL) err_ff <= ST_OVER;
                  else begin
                     count_ff <= count_ff + CW'(1);
                     if (count_ff == '0) bottom_ff <= VALUE_WIDTH'(tok_data.digit);
                  end
                  state_ff <= tok_data.last ? S_OUT : S_IDLE;
               end else if (tok_data.op != OP_PUSH && tok_data.op != OP_NONE
                            && err_ff == ST_OK) begin
                  if (count_ff < CW'(2)) begin
                     err_ff   <= ST_UNDER;
                     state_ff <= tok_data.last ? S_OUT : S_IDLE;
                  end else state_ff <= S_RD1;
               end else state_ff <= tok_data.last ? S_OUT : S_IDLE;
            end
            S_RD1: state_ff <= S_RD2;
            S_RD2: begin
               sec_ff   <= rdata_ff;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               top_ff <= rdata_ff;
               state_ff <= S_DIV;
               step_ff  <= '0;
            end
            S_DIV: begin
               case (tok_ff.op)
                  OP_ADD: begin res_ff <= sec_ff + top_ff; state_ff <= S_FIN; end
                  OP_SUB: begin res_ff <= sec_ff - top_ff; state_ff <= S_FIN; end
                  OP_MUL: begin res_ff <= sec_ff * top_ff; state_ff <= S_FIN; end
                  default: begin
                     if (top_ff == '0) begin
                        err_ff   <= ST_DIVZ;
                        state_ff <= tok_ff.last ? S_OUT : S_IDLE;
                     end else if (step_ff == '0) begin
                        quo_ff  <= mag_a;
                        den_ff  <= mag_b;
                        rem_ff  <= '0;
                        neg_ff  <= sec_ff[VALUE_WIDTH-1] ^ top_ff[VALUE_WIDTH-1];
                        step_ff <= QW'(1);
                     end else begin
                        if (!trial[VALUE_WIDTH]) begin
                           rem_ff <= trial;
                           quo_ff <= {quo_ff[VALUE_WIDTH-2:0], 1'b1};
                        end else begin
                           rem_ff <= {rem_ff[VALUE_WIDTH-1:0], quo_ff[VALUE_WIDTH-1]};
                           quo_ff <= {quo_ff[VALUE_WIDTH-2:0], 1'b0};
                        end
                        step_ff <= step_ff + QW'(1);
                        if (step_ff == QW'(VALUE_WIDTH)) begin
                           res_ff <= neg_ff
                              ? -{quo_ff[VALUE_WIDTH-2:0], !trial[VALUE_WIDTH]}
                              : {quo_ff[VALUE_WIDTH-2:0], !trial[VALUE_WIDTH]};
                           state_ff <= S_FIN;
                        end
                     end
                  end
               endcase
            end
            S_FIN: begin
               count_ff <= count_ff - CW'(1);
               if (count_ff == CW'(2)) bottom_ff <= res_ff;
               state_ff <= tok_ff.last ? S_OUT : S_IDLE;
            end
            S_OUT: if (!rsp_valid_ff) begin
               rsp_valid_ff <= 1'b1;
               if (tok_ff.early != ST_OK) rsp_status_ff <= tok_ff.early;
               else rsp_status_ff <= err_ff;
               rsp_value_ff <= (tok_ff.early == ST_OK && err_ff == ST_OK
                                && count_ff != '0) ? 32'(bottom_ff) : 32'd0;
               count_ff <= '0;
               err_ff   <= ST_OK;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL)
      else $error("stack count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |-> (count_ff >= CW'(2))) else $error("pop without operands");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff) else $error("result dropped");

endmodule

// File: rtl/rpn_expression_evaluator.sv
// Top level of the RPN expression evaluator
//  channel | ports                              | dir
//  req     | req_valid req_ready expr/last_byte | in
//  rsp     | rsp_valid rsp_ready value status   | out
// A character that does not end a token is only stored in the front end.
// Back end: digits push in S_IDLE; operators run S_RD1 to S_FIN, / bit-serial in S_DIV.
// The final token passes S_OUT to post the result; state clears for the next expression.
// Synchronous active-high reset; no clearing pass, stack entries are written before read.
// A full token queue stalls req_ready; an untaken result holds the back end at the next
// final token.
module rpn_expression_evaluator #(
   parameter int STACK_DEPTH = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_expr_byte,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_value,
   output logic [2:0]         rsp_status
);
   import rpn_pkg::*;

   logic      f_valid, f_ready, b_valid, b_ready;
   token_type f_data, b_data;

   rpn_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_expr_byte, .req_last_byte,
      .tok_valid(f_valid), .tok_ready(f_ready), .tok_data(f_data)
   );

   rpn_fifo u_fifo (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   rpn_back #(.STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
      .clock, .reset, .tok_valid(b_valid), .tok_ready(b_ready), .tok_data(b_data),
      .rsp_valid, .rsp_ready, .rsp_value, .rsp_status
   );

endmodule

// File: bench/tb_rpn_expression_evaluator.sv
// Testbench for the RPN expression evaluator: predicts each result and checks it
`timescale 1ns / 1ps
module tb_rpn_expression_evaluator;
   import rpn_pkg::*;

   localparam int DEPTH = 64;
   localparam int LIMIT = 2000000;
   localparam int HOLD_CYCLES = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_expr_byte = 8'h00;
   logic req_last_byte = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_value;
   logic [2:0] rsp_status;

   typedef struct {
      logic [31:0] value;
      status_type  status;
   } result_type;

   result_type pending_results[$];
   int errors = 0;
   int results_seen = 0;
   int items_sent = 0;
   int cycles = 0;
   bit send_idle = 1'b1;
   bit recv_idle = 1'b1;
   bit recv_hold = 1'b0;

   logic [31:0] stk [DEPTH];
   int          stk_count;
   logic [7:0]  tok_char;
   int          tok_len;
   int          tok_total;
   bit          bad_seen;
   status_type  err;

   rpn_expression_evaluator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_expr_byte(req_expr_byte), .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_value(rsp_value), .rsp_status(rsp_status)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout at cycle %0d", cycles);
         $display("status: fail");
         $finish;
      end
   end

   task automatic clear_model();
      stk_count = 0;
      tok_char = 8'h00;
      tok_len = 0;
      tok_total = 0;
      bad_seen = 1'b0;
      err = ST_OK;
   endtask

   function automatic logic [31:0] divide_trunc(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      return (a[31] ^ b[31]) ? -q : q;
   endfunction

   task automatic push_value(logic [31:0] v);
      if (stk_count >= DEPTH) err = ST_OVER;
      else begin
         stk[stk_count] = v;
         stk_count++;
      end
   endtask

   task automatic close_token();
      logic [7:0] c;
      logic [31:0] top, sec, r;
      bit is_digit, is_op;
      c = tok_char;
      is_digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
      is_op = (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_MUL || c == CHAR_DIV);
      if (tok_len == 0) return;
      if (tok_total < MIN_TOKENS) tok_total++;
      if (tok_len >= 2 || (!is_digit && !is_op)) bad_seen = 1'b1;
      else if (err == ST_OK) begin
         if (is_digit) push_value(32'(c - CHAR_ZERO));
         else if (stk_count < 2) err = ST_UNDER;
         else begin
            top = stk[stk_count-1];
            sec = stk[stk_count-2];
            if (c == CHAR_DIV && top == 0) err = ST_DIVZ;
            else begin
               case (c)
                  CHAR_PLUS:  r = sec + top;
                  CHAR_MINUS: r = sec - top;
                  CHAR_MUL:   r = sec * top;
                  default:    r = divide_trunc(sec, top);
               endcase
               stk_count -= 2;
               push_value(r);
            end
         end
      end
      tok_len = 0;
      tok_char = 8'h00;
   endtask

   task automatic predict_char(logic [7:0] c, logic last);
      result_type res;
      if (c == CHAR_SPACE) close_token();
      else begin
         if (tok_len == 0) tok_char = c;
         if (tok_len < 2) tok_len++;
      end
      if (!last) return;
      close_token();
      if (bad_seen) res.status = ST_BAD;
      else if (tok_total < MIN_TOKENS) res.status = ST_FEW;
      else res.status = err;
      res.value = (res.status == ST_OK && stk_count > 0) ? stk[0] : 32'd0;
      pending_results = {pending_results, res};
      clear_model();
   endtask

   task automatic send_char(logic [7:0] c, logic last);
      int gap;
      if (send_idle && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_expr_byte <= c;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_char(c, last);
      items_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   always @(posedge clock) begin
      result_type exp_res;
      if (rsp_valid && rsp_ready && !reset) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result value %0d status %0d", $time, rsp_value,
                     rsp_status);
            errors++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_value !== exp_res.value) begin
               $display("%0t: value expected %0d actual %0d", $time,
                        $signed(exp_res.value), rsp_value);
               errors++;
            end
            if (rsp_status !== exp_res.status) begin
               $display("%0t: status expected %0d actual %0d", $time, exp_res.status,
                        rsp_status);
               errors++;
            end
         end
      end
   end

   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (recv_hold) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            recv_hold = 1'b0;
         end else if (recv_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_ready <= 1'b1;
         end else rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   function automatic logic [7:0] random_token();
      case ($urandom_range(0, 4))
         0, 1: return CHAR_ZERO + 8'($urandom_range(0, 9));
         2: return CHAR_PLUS;
         3: return CHAR_MUL;
         default: return ($urandom_range(0, 1) != 0) ? CHAR_MINUS : CHAR_DIV;
      endcase
   endfunction

   task automatic send_random_expr();
      int n, depth;
      logic [7:0] t;
      n = $urandom_range(1, 12);
      depth = 0;
      for (int i = 0; i < n; i++) begin
         if (depth < 2 || $urandom_range(0, 1) == 0) t = CHAR_ZERO + 8'($urandom_range(0, 9));
         else t = random_token();
         if ($urandom_range(0, 29) == 0) t = 8'($urandom_range(0, 255));
         if (t >= CHAR_ZERO && t <= CHAR_NINE) depth++;
         else if (depth > 0) depth--;
         send_char(t, 1'b0);
         if ($urandom_range(0, 39) == 0) send_char(8'($urandom_range(0, 255)), 1'b0);
         send_char(CHAR_SPACE, 1'b0);
         if ($urandom_range(0, 9) == 0) send_char(CHAR_SPACE, 1'b0);
      end
      send_char(($urandom_range(0, 3) == 0) ? CHAR_SPACE : random_token(), 1'b1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic test_directed();
      send_text("3 4 +");
      send_text("9 3 - 2 *");
      send_text("7 2 /");
      send_text("7 0 /");
      send_text("1 +");
      send_text("12 3 +");
      send_text("1 a +");
      send_text("1 2");
      send_text(" ");
      send_text("  5   6 *  ");
      send_text("1 2 3 +");
      send_text("+ 1 2 a");
      send_char(8'hFF, 1'b1);
      send_char(8'h00, 1'b1);
   endtask

   task automatic test_wrap();
      string s;
      s = "0 1 -";
      for (int i = 0; i < 31; i++) s = {s, " 2 *"};
      send_text({s, " 0 1 - /"});
      send_text({s, " 1 -"});
      send_text("9 9 * 9 * 9 * 9 * 9 * 9 * 9 * 9 * 9 * 9 * 9 *");
   endtask

   task automatic test_overflow();
      string s;
      s = "";
      for (int i = 0; i < DEPTH + 1; i++) s = {s, "5 "};
      send_text({s, "+"});
      s = "";
      for (int i = 0; i < DEPTH; i++) s = {s, "8 "};
      send_text({s, "+"});
   endtask

   task automatic test_backpressure();
      recv_hold = 1'b1;
      for (int i = 0; i < 10; i++) send_text("8 4 / 3 / 1 + 2 /");
      wait_drained();
   endtask

   task automatic test_random(int count);
      while (items_sent < count) send_random_expr();
   endtask

   initial begin
      clear_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_wrap();
      test_overflow();
      wait_drained();
      test_backpressure();
      test_random(1350);
      send_idle = 1'b0;
      recv_idle = 1'b0;
      test_random(1650);
      wait_drained();
      $display("covered directed cases, wraparound, overflow, back pressure and random");
      $display("%0d items sent, %0d results checked", items_sent, results_seen);
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

// File: sim.f
rtl/rpn_pkg.sv
rtl/rpn_front.sv
rtl/rpn_fifo.sv
rtl/rpn_back.sv
rtl/rpn_expression_evaluator.sv
bench/tb_rpn_expression_evaluator.sv
